FILE: hw/rtl/bhmp_pkg.sv
package bhmp_pkg;

  localparam int unsigned ElemW = 32;
  localparam int unsigned AccW  = 50;

  // command from controller to datapath
  typedef struct packed {
    logic       load;     // capture input item
    logic       mac_clr;  // clear accumulators
    logic       mac_en;   // accumulate one product term
    logic [1:0] kk;       // term index
    logic       mode_fin; // 0: row times parent, 1: offset times to-root
    logic [1:0] jj;       // output column for final product
    logic       rowwr;    // write pending row
    logic       rdreq;    // issue parent read for term kk
    logic       stwr;     // store to-root element
    logic [3:0] stidx;    // element to store
    logic       outld;    // load output register
  } bhmp_cmd_t;

  typedef struct packed {
    logic       is_root;
    logic [1:0] row;
  } bhmp_sts_t;

  function automatic logic signed [ElemW-1:0] sat32(input logic signed [AccW-1:0] s);
    logic signed [AccW-1:0] maxv;
    logic signed [AccW-1:0] minv;
    maxv = AccW'(64'sh7FFF_FFFF);
    minv = -AccW'(64'sh8000_0000);
    if (s > maxv) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (s < minv) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = s[ElemW-1:0];
    end
  endfunction

endpackage

FILE: hw/rtl/bhmp_ctrl.sv
module bhmp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_busy_i,
  input  bhmp_pkg::bhmp_sts_t sts_i,
  output bhmp_pkg::bhmp_cmd_t cmd_o
);
  import bhmp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ROW, S_STORE, S_FIN, S_WAIT
  } state_e;

  state_e     state_q;
  logic [5:0] cnt_q;
  logic [2:0] jcnt_q;

  assign in_ready_o = (state_q == S_IDLE);

  // row phase: cnt 0..3 issue reads kk=cnt (registered read data), accumulate kk=cnt-1
  // final phase per column: cnt 0..3 accumulate, cnt 4 load output
  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    case (state_q)
      S_ROW: begin
        cmd_o.rdreq   = (cnt_q < 6'd4);
        cmd_o.kk      = cnt_q[1:0];
        cmd_o.mac_clr = (cnt_q == 6'd0);
        cmd_o.mac_en  = (cnt_q != 6'd0) && (cnt_q < 6'd5);
        cmd_o.rowwr   = (cnt_q == 6'd5);
      end
      S_STORE: begin
        cmd_o.stwr  = 1'b1;
        cmd_o.stidx = cnt_q[3:0];
      end
      S_FIN: begin
        cmd_o.mode_fin = 1'b1;
        cmd_o.jj       = jcnt_q[1:0];
        cmd_o.kk       = cnt_q[1:0];
        cmd_o.mac_clr  = (cnt_q == 6'd0);
        cmd_o.mac_en   = (cnt_q < 6'd4);
      end
      S_WAIT: begin
        cmd_o.mode_fin = 1'b1;
        cmd_o.jj       = jcnt_q[1:0];
        cmd_o.outld    = !out_busy_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      jcnt_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) state_q <= S_ROW;
        end
        S_ROW: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd5) begin
            cnt_q <= '0;
            state_q <= (sts_i.row == 2'd3) ? S_STORE : S_IDLE;
          end
        end
        S_STORE: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd15) begin
            cnt_q   <= '0;
            jcnt_q  <= '0;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd3) state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (!out_busy_i) begin
            cnt_q  <= '0;
            jcnt_q <= jcnt_q + 3'd1;
            state_q <= (jcnt_q == 3'd3) ? S_IDLE : S_FIN;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/bhmp_dp.sv
module bhmp_dp #(
  parameter int unsigned MaxBones = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [7:0]                bone_i,
  input  logic [8:0]                parent_i,
  input  logic [1:0]                row_i,
  input  logic [4*32-1:0]           loc_i,
  input  logic [4*32-1:0]           bnd_i,
  input  bhmp_pkg::bhmp_cmd_t        cmd_i,
  output bhmp_pkg::bhmp_sts_t        sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      out_busy_o,
  output logic [7:0]                out_bone_o,
  output logic [1:0]                out_row_o,
  output logic [4*32-1:0]           out_val_o,
  output logic                      out_last_o
);
  import bhmp_pkg::*;

  localparam int unsigned BW = (MaxBones > 1) ? $clog2(MaxBones) : 1;

  logic [7:0]              bone_q;
  logic [8:0]              par_q;
  logic [1:0]              row_q;
  logic signed [31:0]      loc_q [4];
  logic signed [31:0]      pbnd_q [16];
  logic signed [31:0]      prow_q [16];
  logic signed [AccW-1:0]  acc_q [4];
  logic [1:0]              kd_q;

  // bone index folded into the store range, constant lookup over all 8-bit values
  function automatic logic [BW-1:0] idx_mod(input logic [7:0] x);
    idx_mod = '0;
    for (int i = 0; i < 256; i++) begin
      if (x == 8'(i)) idx_mod = BW'(i % MaxBones);
    end
  endfunction

  logic [BW-1:0] par_idx;
  logic [BW-1:0] bone_idx;
  assign par_idx  = idx_mod(par_q[7:0]);
  assign bone_idx = idx_mod(bone_q);

  assign sts_o.is_root = par_q[8];
  assign sts_o.row     = row_q;

  // one bank per column, each read at {parent, row kk} with registered data
  logic signed [31:0] rdv [4];
  genvar g;
  for (g = 0; g < 4; g++) begin : g_bank
    logic signed [31:0] bank [MaxBones*4];
    logic signed [31:0] bq;
    always_ff @(posedge clk_i) begin
      if (cmd_i.stwr && cmd_i.stidx[1:0] == 2'(g)) begin
        bank[(BW+2)'({bone_idx, cmd_i.stidx[3:2]})] <= prow_q[cmd_i.stidx];
      end
      if (cmd_i.rdreq) begin
        bq <= bank[(BW+2)'({par_idx, cmd_i.kk})];
      end
    end
    assign rdv[g] = bq;
  end

  // operands for the four lanes
  logic signed [31:0] opa [4];
  logic signed [31:0] opb [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (cmd_i.mode_fin) begin
        opa[l] = pbnd_q[l*4 + int'(cmd_i.kk)];
        opb[l] = prow_q[int'(cmd_i.kk)*4 + int'(cmd_i.jj)];
      end else begin
        opa[l] = loc_q[kd_q];
        opb[l] = rdv[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bone_q <= bone_i;
      par_q  <= parent_i;
      row_q  <= row_i;
      for (int l = 0; l < 4; l++) loc_q[l] <= loc_i[l*32 +: 32];
    end
    kd_q <= cmd_i.kk;
    for (int l = 0; l < 4; l++) begin
      logic signed [63:0] p;
      p = 64'(opa[l]) * 64'(opb[l]);
      if (cmd_i.mac_clr && !cmd_i.mac_en) begin
        acc_q[l] <= '0;
      end else if (cmd_i.mac_en) begin
        acc_q[l] <= (cmd_i.mac_clr ? AccW'(0) : acc_q[l]) + AccW'(p >>> 16);
      end
    end
    if (cmd_i.load) begin
      for (int l = 0; l < 4; l++) pbnd_q[int'(row_i)*4 + l] <= bnd_i[l*32 +: 32];
    end
    if (cmd_i.rowwr) begin
      for (int l = 0; l < 4; l++) begin
        prow_q[int'(row_q)*4 + l] <= par_q[8] ? loc_q[l] : sat32(acc_q[l]);
      end
    end
  end

  // output register
  logic vld_q;
  assign out_busy_o  = vld_q && !out_ready_i;
  assign out_valid_o = vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (cmd_i.outld) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.outld) begin
      out_bone_o <= bone_q;
      out_row_o  <= cmd_i.jj;
      out_last_o <= (cmd_i.jj == 2'd3);
      for (int l = 0; l < 4; l++) out_val_o[l*32 +: 32] <= sat32(acc_q[l]);
    end
  end

endmodule

FILE: hw/rtl/bone_hierarchy_matrix_palette_core.sv
// skinning matrix palette: each input item is one row of a bone's local
// transform and offset matrix, bones sent parent before child with rows 0..3
// in order. each row is multiplied by the parent's stored to-root matrix
// (four lanes, one term per cycle, one parent word per bank per cycle) or taken
// as is for a root; after row 3 the to-root matrix is written to the palette
// store (one element a cycle through a single write port) and offset times
// to-root goes out as four items, one column each, tlast on the fourth. rows
// and output columns share one four-lane multiply bank; a new row is taken
// only when the core is idle. q16.16 values, products floored, sums saturated.
// store contents are undefined until written.
module bone_hierarchy_matrix_palette_core #(
  parameter int unsigned MAX_BONES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // bone_number[7:0], parent_number[16:8], row_number[18:17],
  // local_a..d [146:19], bind_a..d [274:147], zero fill to 280
  input  logic [279:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_bone[7:0], out_row[9:8], val_a..d [137:10], zero fill to 144
  output logic [143:0] m_axis_tdata,
  // bone_done
  output logic         m_axis_tlast
);
  import bhmp_pkg::*;

  bhmp_cmd_t cmd;
  bhmp_sts_t sts;
  logic busy;
  logic [7:0] ob;
  logic [1:0] orow;
  logic [127:0] ov;

  bhmp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_busy_i(busy), .sts_i(sts), .cmd_o(cmd)
  );

  bhmp_dp #(.MaxBones(MAX_BONES)) u_dp (
    .clk_i, .rst_ni,
    .bone_i(s_axis_tdata[7:0]), .parent_i(s_axis_tdata[16:8]),
    .row_i(s_axis_tdata[18:17]),
    .loc_i(s_axis_tdata[146:19]), .bnd_i(s_axis_tdata[274:147]),
    .cmd_i(cmd), .sts_o(sts),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_busy_o(busy),
    .out_bone_o(ob), .out_row_o(orow), .out_val_o(ov), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, ov, orow, ob};

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import bhmp_pkg::*;

  localparam int unsigned NBONES = 256;
  localparam int unsigned WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0]  bone;
    logic [1:0]  row;
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] vc;
    logic [31:0] vd;
    logic        done;
  } palette_col_t;

  // scoreboard: own copy of the palette store and the bone in progress
  class palette_scoreboard;
    logic signed [31:0] to_root[NBONES*16];
    logic signed [31:0] cur_rows[16];
    logic signed [31:0] cur_bind[16];
    palette_col_t       pending_cols[$];
    int                 errors;

    function new();
      errors = 0;
      foreach (to_root[i]) to_root[i] = '0;
      foreach (cur_rows[i]) cur_rows[i] = '0;
      foreach (cur_bind[i]) cur_bind[i] = '0;
    endfunction

    // product with low 16 bits dropped, floor semantics by arithmetic shift
    function logic signed [63:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p >>> 16;
    endfunction

    function logic signed [31:0] sat(logic signed [63:0] s);
      if (s > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (s < -64'sh8000_0000) return 32'sh8000_0000;
      return s[31:0];
    endfunction

    function void note_row(logic [279:0] d);
      logic [7:0]         bone;
      logic [8:0]         par;
      logic [1:0]         row;
      logic signed [31:0] loc[4];
      logic signed [63:0] s;
      int unsigned        pb;
      palette_col_t       c;
      logic signed [31:0] v[4];
      bone = d[7:0];
      par  = d[16:8];
      row  = d[18:17];
      for (int i = 0; i < 4; i++) begin
        loc[i] = d[19+32*i +: 32];
        cur_bind[row*4+i] = d[147+32*i +: 32];
      end
      pb = (par % NBONES) * 16;
      for (int j = 0; j < 4; j++) begin
        if (par[8]) begin
          cur_rows[row*4+j] = loc[j];
        end else begin
          s = 0;
          for (int k = 0; k < 4; k++) s += qmul(loc[k], to_root[pb+k*4+j]);
          cur_rows[row*4+j] = sat(s);
        end
      end
      if (row != 2'd3) return;
      for (int i = 0; i < 16; i++) to_root[(bone % NBONES)*16+i] = cur_rows[i];
      // column j of offset times to-root
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 4; i++) begin
          s = 0;
          for (int k = 0; k < 4; k++) s += qmul(cur_bind[i*4+k], cur_rows[k*4+j]);
          v[i] = sat(s);
        end
        c.bone = bone; c.row = 2'(j);
        c.va = v[0]; c.vb = v[1]; c.vc = v[2]; c.vd = v[3];
        c.done = (j == 3);
        pending_cols.push_back(c);
      end
    endfunction

    function void check_col(logic [143:0] d, logic last);
      palette_col_t e;
      palette_col_t a;
      a.bone = d[7:0]; a.row = d[9:8];
      a.va = d[41:10]; a.vb = d[73:42]; a.vc = d[105:74]; a.vd = d[137:106];
      a.done = last;
      if (pending_cols.size() == 0) begin
        $display("%0t: unexpected item %h", $time, a);
        errors++;
        return;
      end
      e = pending_cols.pop_front();
      if (e.bone != a.bone) begin
        $display("%0t: bone exp %0d got %0d", $time, e.bone, a.bone); errors++;
      end
      if (e.row != a.row) begin
        $display("%0t: row exp %0d got %0d", $time, e.row, a.row); errors++;
      end
      if (e.va != a.va) begin
        $display("%0t: val_a exp %h got %h", $time, e.va, a.va); errors++;
      end
      if (e.vb != a.vb) begin
        $display("%0t: val_b exp %h got %h", $time, e.vb, a.vb); errors++;
      end
      if (e.vc != a.vc) begin
        $display("%0t: val_c exp %h got %h", $time, e.vc, a.vc); errors++;
      end
      if (e.vd != a.vd) begin
        $display("%0t: val_d exp %h got %h", $time, e.vd, a.vd); errors++;
      end
      if (e.done != a.done) begin
        $display("%0t: tlast exp %0b got %0b", $time, e.done, a.done); errors++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [279:0] s_axis_tdata;   // bone, parent, row, local_a..d, bind_a..d
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;   // out_bone, out_row, val_a..d
  logic         m_axis_tlast;   // bone_done

  bone_hierarchy_matrix_palette_core #(.MAX_BONES(NBONES)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  palette_scoreboard sb = new();
  bit   written[NBONES];       // bones whose to-root matrix exists
  bit   hold_rx;               // long receiver hold-off request
  int   idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // monitors sample at the edge where both handshake lines are high
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_row(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_col(m_axis_tdata, m_axis_tlast);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls per item, plus a long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  function automatic logic [31:0] rand_elem(int mode);
    case (mode)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  // send one row; gap drawn per item unless burst mode
  task automatic send_row(logic [7:0] bone, logic [8:0] par, logic [1:0] row,
                          int mode, bit no_gap);
    logic [279:0] d;
    int           gap;
    d = '0;
    d[7:0] = bone; d[16:8] = par; d[18:17] = row;
    for (int i = 0; i < 8; i++) d[19+32*i +: 32] = rand_elem(mode < 0 ? $urandom_range(0, 4) : mode);
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // a bone whose parent already exists, or a root
  task automatic send_bone(logic [7:0] bone, int mode, bit no_gap);
    logic [8:0] par;
    int         p;
    par = 9'h1FF;
    if ($urandom_range(0, 3) != 0) begin
      p = $urandom_range(0, NBONES - 1);
      if (written[p]) par = 9'(p);
      else if ($urandom_range(0, 1)) par = 9'h100 | 9'($urandom_range(0, 255));
    end
    for (int r = 0; r < 4; r++) send_row(bone, par, 2'(r), mode, no_gap);
    written[bone] = 1'b1;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_cols.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    // directed: roots with extreme values, all 1.0 elements, child and self parent
    for (int r = 0; r < 4; r++) send_row(8'd0, 9'h1FF, 2'(r), 2, 1'b0);
    written[0] = 1'b1;
    for (int r = 0; r < 4; r++) send_row(8'd255, 9'h1FF, 2'(r), 0, 1'b0);
    written[255] = 1'b1;
    for (int r = 0; r < 4; r++) send_row(8'd1, 9'd255, 2'(r), 1, 1'b0);
    written[1] = 1'b1;
    // self parent reads the old entry; negative non -1 parent is a root
    for (int r = 0; r < 4; r++) send_row(8'd1, 9'd1, 2'(r), 3, 1'b0);
    for (int r = 0; r < 4; r++) send_row(8'd2, 9'h100, 2'(r), 4, 1'b0);
    written[2] = 1'b1;
    // rows out of order: slots keep older data
    send_row(8'd3, 9'd0, 2'd1, 4, 1'b0);
    send_row(8'd3, 9'd2, 2'd3, 4, 1'b0);
    written[3] = 1'b1;
    // sender pauses until all results are back
    drain();
    // receiver holds off while sender keeps offering
    hold_rx = 1'b1;
    for (int b = 0; b < 6; b++) send_bone(8'($urandom_range(0, 255)), -1, 1'b1);
    // random: mostly well-formed bones, some broken sequences
    for (int n = 0; n < 95; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_row(8'($urandom), written[0] ? 9'd0 : 9'h1FF, 2'($urandom_range(0, 2)),
                 -1, 1'b0);
      end else begin
        send_bone(8'($urandom), -1, $urandom_range(0, 4) == 0);
      end
    end
    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_cols.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
